### rtl/vcls_pkg.sv
// vcls_pkg: shared codes and types of the variable-coefficient stencil block
// no dependencies; imported by vcls_store, the top level, the checker and the testbench
`timescale 1ns / 1ps

package vcls_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_H      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_V      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DX_SQ   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DY_SQ   = 3'd5;

  // read port order: centre, east, west, north, south
  localparam int P_C = 0;
  localparam int P_E = 1;
  localparam int P_W = 2;
  localparam int P_N = 3;
  localparam int P_S = 4;
  localparam int NPORT = 5;

  typedef struct packed {
    logic [31:0] pot;
    logic        act;
  } vcls_cell_t;

  // transaction state right after the store read
  typedef struct packed {
    logic       valid;
    logic       outside;
    logic [3:0] fen;      // face exists: east, west, north, south
  } vcls_req_t;

  // transaction state carried alongside the face arithmetic
  typedef struct packed {
    logic        valid;
    logic        outside;
    logic        ctr_active;
    logic [31:0] ctr_pot;
  } vcls_ctl_t;

endpackage

### rtl/vcls_store.sv
// vcls_store: cell storage, one copy per read port so five neighbours read at once
// depends on vcls_pkg
`timescale 1ns / 1ps

module vcls_store import vcls_pkg::*; #(
  parameter int NCELL = 4096,
  parameter int AW    = 12
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  vcls_cell_t                  wr_cell,
  input  logic [31:0]                 wr_east,
  input  logic [31:0]                 wr_north,
  input  logic [NPORT-1:0][AW-1:0]    rd_addr,
  output vcls_cell_t [NPORT-1:0]      rd_cell,
  output logic [1:0][31:0]            rd_east,   // centre, west
  output logic [1:0][31:0]            rd_north   // centre, south
);

  for (genvar p = 0; p < NPORT; p++) begin : g_cell
    vcls_cell_t mem [NCELL];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_cell;
      end
      rd_cell[p] <= mem[rd_addr[p]];
    end
  end

  for (genvar p = 0; p < 2; p++) begin : g_coef
    localparam int EA = (p == 0) ? P_C : P_W;
    localparam int NA = (p == 0) ? P_C : P_S;
    logic [31:0] east_mem [NCELL];
    logic [31:0] north_mem [NCELL];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        east_mem[wr_addr]  <= wr_east;
        north_mem[wr_addr] <= wr_north;
      end
      rd_east[p]  <= east_mem[rd_addr[EA]];
      rd_north[p] <= north_mem[rd_addr[NA]];
    end
  end

endmodule

### rtl/vcls_face.sv
// vcls_face: one face term coeff * d * inv_sq, four register stages
// no package dependency
`timescale 1ns / 1ps

module vcls_face (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        coeff,
  input  logic signed [32:0] diff,
  input  logic [31:0]        inv_sq,
  output logic signed [31:0] term,
  output logic               sat
);

  logic        en1_r, en2_r, en3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [31:0] mag1_r, coeff1_r;
  logic [47:0] m1_r;
  logic [63:0] hi_r;
  logic [47:0] lo_r;
  logic [63:0] prod1, lo_full;
  logic [64:0] sum2;
  logic [32:0] m2;
  logic [32:0] diff_abs;
  logic signed [31:0] term_nxt;
  logic        sat_nxt;

  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  assign prod1    = 64'(coeff1_r) * 64'(mag1_r);
  assign lo_full  = 64'(m1_r) * 64'(inv_sq[15:0]);
  assign sum2     = 65'(hi_r) + 65'(lo_r);
  assign m2       = (sum2 >= 65'h1_0000_0000) ? 33'h1_0000_0000 : sum2[32:0];

  always_comb begin
    term_nxt = '0;
    sat_nxt  = 1'b0;
    if (en3_r) begin
      if (!neg3_r) begin
        if (m2 > 33'h0_7FFF_FFFF) begin
          term_nxt = 32'sh7FFF_FFFF;
          sat_nxt  = 1'b1;
        end else begin
          term_nxt = signed'(m2[31:0]);
        end
      end else begin
        if (m2 > 33'h0_8000_0000) begin
          term_nxt = 32'sh8000_0000;
          sat_nxt  = 1'b1;
        end else begin
          term_nxt = signed'(32'(-m2));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    en1_r    <= en;
    neg1_r   <= diff[32];
    mag1_r   <= diff_abs[31:0];
    coeff1_r <= coeff;
    en2_r    <= en1_r;
    neg2_r   <= neg1_r;
    m1_r     <= prod1[63:16];
    en3_r    <= en2_r;
    neg3_r   <= neg2_r;
    hi_r     <= 64'(m1_r) * 64'(inv_sq[31:16]);
    lo_r     <= lo_full[63:16];
    term     <= term_nxt;
    sat      <= sat_nxt;
  end

endmodule

### rtl/vcls_sum.sv
// vcls_sum: saturating sum of the four face terms in east, west, north, south order
// no package dependency; one register stage, final add left combinational
`timescale 1ns / 1ps

module vcls_sum (
  input  logic                    clk,
  input  logic [3:0][31:0]        terms,
  input  logic [3:0]              sats,
  output logic signed [31:0]      sum,
  output logic                    sat
);

  function automatic logic [32:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic signed [33:0] s;
    begin
      s = 34'(signed'(a)) + 34'(signed'(b));
      if (s > 34'sh0_7FFF_FFFF) begin
        sat_add = {1'b1, 32'h7FFF_FFFF};
      end else if (s < -34'sh0_8000_0000) begin
        sat_add = {1'b1, 32'h8000_0000};
      end else begin
        sat_add = {1'b0, s[31:0]};
      end
    end
  endfunction

  logic [32:0] ew, ewn, fin;
  logic [31:0] acc_r, south_r;
  logic        sat_r;

  assign ew  = sat_add(terms[0], terms[1]);
  assign ewn = sat_add(ew[31:0], terms[2]);
  assign fin = sat_add(acc_r, south_r);

  always_ff @(posedge clk) begin
    acc_r   <= ewn[31:0];
    south_r <= terms[3];
    sat_r   <= (|sats) | ew[32] | ewn[32];
  end

  assign sum = signed'(fin[31:0]);
  assign sat = sat_r | fin[32];

endmodule

### rtl/variable_coeff_laplacian_stencil.sv
// variable_coeff_laplacian_stencil: grid store and five-point variable-coefficient operator
// depends on vcls_pkg, vcls_store, vcls_face, vcls_sum
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low. kind 0
//   loads one cell (no result); kind 1 evaluates the operator at one cell.
//   busy is high during reset and in the first cycle after it, and low from then
//   on, so one transaction can enter every cycle.
//   Each evaluate gives one result, out_valid high for one cycle, after it has
//   passed the store read, the face multipliers, the sum register and the output
//   register. Results come out in transaction order; a load leaves an empty slot.
//   Throughput is one transaction per cycle: every read port of the store has
//   its own copy of the cell memory, and the face terms run in a 4-stage
//   multiplier pipeline (coeff * |d|, then * inv_sq in two 16-bit halves).
//   A load is visible to an evaluate taken in the very next cycle.
//   Configuration: cfg_ready is always high; write only while no evaluate is in
//   flight. Unknown indexes are ignored.
//   Reset (synchronous, rst_n low) restores the configuration defaults and
//   empties the pipeline; cell contents are not cleared and must be loaded
//   before they are read. The receiver cannot stall results.
`timescale 1ns / 1ps

module variable_coeff_laplacian_stencil import vcls_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [5:0]            in_cell_col,
  input  logic [5:0]            in_cell_row,
  input  logic signed [31:0]    in_potential,
  input  logic [31:0]           in_east_coeff,
  input  logic [31:0]           in_north_coeff,
  input  logic                  in_active_bit,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  out_valid,
  output logic signed [31:0]    out_operator_value,
  output logic [1:0]            out_status
);

  localparam int NCELL = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(NCELL);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int WC    = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
  localparam int WR    = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
  localparam int CTL_DEPTH = 5;

  logic        busy_r;
  logic [6:0]  grid_width_r, grid_height_r;
  logic        wrap_h_r, wrap_v_r;
  logic [31:0] inv_dx_sq_r, inv_dy_sq_r;

  logic        accept;
  logic [WC-1:0] w, col, col_e, col_w;
  logic [WR-1:0] h, row, row_n, row_s;
  logic        load_ok;
  logic [AW-1:0] wr_addr;
  logic [NPORT-1:0][AW-1:0] rd_addr;
  vcls_cell_t [NPORT-1:0]   rd_cell;
  logic [1:0][31:0] rd_east, rd_north;
  vcls_cell_t  wr_cell;
  vcls_req_t   req_nxt, req_r;
  vcls_ctl_t   ctl_nxt;
  vcls_ctl_t   ctl_r [CTL_DEPTH];
  logic [3:0][31:0] terms;
  logic [3:0]  sats;
  logic [3:0][31:0] face_coeff;
  logic signed [31:0] sum;
  logic        sum_sat;

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b1;
      grid_width_r  <= 7'd64;
      grid_height_r <= 7'd64;
      wrap_h_r      <= 1'b1;
      wrap_v_r      <= 1'b1;
      inv_dx_sq_r   <= 32'h0001_0000;
      inv_dy_sq_r   <= 32'h0001_0000;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width_r  <= cfg_data[6:0];
          REG_GRID_HEIGHT: grid_height_r <= cfg_data[6:0];
          REG_WRAP_H:      wrap_h_r      <= cfg_data[0];
          REG_WRAP_V:      wrap_v_r      <= cfg_data[0];
          REG_INV_DX_SQ:   inv_dx_sq_r   <= cfg_data;
          REG_INV_DY_SQ:   inv_dy_sq_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // effective grid size, zero used as one and clipped to the store
  always_comb begin
    if (grid_width_r == 7'd0) begin
      w = WC'(1);
    end else if (WC'(grid_width_r) > WC'(MAX_COLS)) begin
      w = WC'(MAX_COLS);
    end else begin
      w = WC'(grid_width_r);
    end
    if (grid_height_r == 7'd0) begin
      h = WR'(1);
    end else if (WR'(grid_height_r) > WR'(MAX_ROWS)) begin
      h = WR'(MAX_ROWS);
    end else begin
      h = WR'(grid_height_r);
    end
  end

  assign col   = WC'(in_cell_col);
  assign row   = WR'(in_cell_row);
  assign col_e = (col + WC'(1) < w) ? col + WC'(1) : '0;
  assign col_w = (col != '0) ? col - WC'(1) : w - WC'(1);
  assign row_n = (row + WR'(1) < h) ? row + WR'(1) : '0;
  assign row_s = (row != '0) ? row - WR'(1) : h - WR'(1);

  function automatic logic [AW-1:0] cell_addr(input logic [RB-1:0] r, input logic [CB-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  assign rd_addr[P_C] = cell_addr(row[RB-1:0], col[CB-1:0]);
  assign rd_addr[P_E] = cell_addr(row[RB-1:0], col_e[CB-1:0]);
  assign rd_addr[P_W] = cell_addr(row[RB-1:0], col_w[CB-1:0]);
  assign rd_addr[P_N] = cell_addr(row_n[RB-1:0], col[CB-1:0]);
  assign rd_addr[P_S] = cell_addr(row_s[RB-1:0], col[CB-1:0]);

  assign load_ok = accept && (in_kind == KIND_LOAD) && (col < WC'(MAX_COLS))
                   && (row < WR'(MAX_ROWS));
  assign wr_addr = rd_addr[P_C];
  assign wr_cell = '{pot: in_potential, act: in_active_bit};

  vcls_store #(.NCELL(NCELL), .AW(AW)) u_store (
    .clk      (clk),
    .wr_en    (load_ok),
    .wr_addr  (wr_addr),
    .wr_cell  (wr_cell),
    .wr_east  (in_east_coeff),
    .wr_north (in_north_coeff),
    .rd_addr  (rd_addr),
    .rd_cell  (rd_cell),
    .rd_east  (rd_east),
    .rd_north (rd_north)
  );

  always_comb begin
    req_nxt.valid   = accept && (in_kind == KIND_EVAL);
    req_nxt.outside = (col >= w) || (row >= h);
    req_nxt.fen[0]  = (col + WC'(1) < w) || wrap_h_r;
    req_nxt.fen[1]  = (col != '0) || wrap_h_r;
    req_nxt.fen[2]  = (row + WR'(1) < h) || wrap_v_r;
    req_nxt.fen[3]  = (row != '0) || wrap_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else begin
      req_r.valid <= req_nxt.valid;
    end
    req_r.outside <= req_nxt.outside;
    req_r.fen     <= req_nxt.fen;
  end

  assign face_coeff[0] = rd_east[0];
  assign face_coeff[1] = rd_east[1];
  assign face_coeff[2] = rd_north[0];
  assign face_coeff[3] = rd_north[1];

  for (genvar f = 0; f < 4; f++) begin : g_face
    logic signed [32:0] diff;
    assign diff = 33'(signed'(rd_cell[P_C].pot)) - 33'(signed'(rd_cell[f + 1].pot));
    vcls_face u_face (
      .clk    (clk),
      .en     (req_r.fen[f] & rd_cell[f + 1].act),
      .coeff  (face_coeff[f]),
      .diff   (diff),
      .inv_sq ((f < 2) ? inv_dx_sq_r : inv_dy_sq_r),
      .term   (terms[f]),
      .sat    (sats[f])
    );
  end

  vcls_sum u_sum (
    .clk   (clk),
    .terms (terms),
    .sats  (sats),
    .sum   (sum),
    .sat   (sum_sat)
  );

  assign ctl_nxt = '{valid: req_r.valid, outside: req_r.outside,
                     ctr_active: rd_cell[P_C].act, ctr_pot: rd_cell[P_C].pot};

  for (genvar s = 0; s < CTL_DEPTH; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s].valid <= 1'b0;
      end else begin
        ctl_r[s].valid <= (s == 0) ? ctl_nxt.valid : ctl_r[(s == 0) ? 0 : s - 1].valid;
      end
      if (s == 0) begin
        ctl_r[s].outside    <= ctl_nxt.outside;
        ctl_r[s].ctr_active <= ctl_nxt.ctr_active;
        ctl_r[s].ctr_pot    <= ctl_nxt.ctr_pot;
      end else begin
        ctl_r[s].outside    <= ctl_r[(s == 0) ? 0 : s - 1].outside;
        ctl_r[s].ctr_active <= ctl_r[(s == 0) ? 0 : s - 1].ctr_active;
        ctl_r[s].ctr_pot    <= ctl_r[(s == 0) ? 0 : s - 1].ctr_pot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl_r[CTL_DEPTH-1].valid;
    end
    if (ctl_r[CTL_DEPTH-1].outside) begin
      out_operator_value <= '0;
      out_status         <= ST_OUTSIDE;
    end else if (!ctl_r[CTL_DEPTH-1].ctr_active) begin
      out_operator_value <= signed'(ctl_r[CTL_DEPTH-1].ctr_pot);
      out_status         <= ST_OK;
    end else begin
      out_operator_value <= sum;
      out_status         <= sum_sat ? ST_SAT : ST_OK;
    end
  end

`ifndef ASSERT_OFF
  a_out_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_kind == KIND_EVAL, 7))
    else $error("result without an evaluate seven cycles earlier");

  a_eval_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_EVAL) |-> ##7 out_valid)
    else $error("evaluate lost in the pipeline");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OUTSIDE) |-> (out_operator_value == 32'sd0))
    else $error("outside-grid result with nonzero value");
`endif

endmodule

### tb/variable_coeff_laplacian_stencil_checker.sv
// checker for the variable-coefficient stencil: watches the config, input and result
// channels, predicts each evaluate from its own copy of grid and registers, and compares
// depends on vcls_pkg
`timescale 1ns / 1ps

module variable_coeff_laplacian_stencil_checker import vcls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_kind,
  input  logic [5:0]           in_cell_col,
  input  logic [5:0]           in_cell_row,
  input  logic signed [31:0]   in_potential,
  input  logic [31:0]          in_east_coeff,
  input  logic [31:0]          in_north_coeff,
  input  logic                 in_active_bit,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 out_valid,
  input  logic signed [31:0]   out_operator_value,
  input  logic [1:0]           out_status,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   sat_seen,
  output int                   outside_seen
);

  localparam int COLS = 64;
  localparam int ROWS = 64;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } stencil_result_t;

  logic [31:0] pot_mem   [COLS*ROWS];
  logic [31:0] east_mem  [COLS*ROWS];
  logic [31:0] north_mem [COLS*ROWS];
  logic        act_mem   [COLS*ROWS];

  logic [6:0]  grid_w, grid_h;
  logic        wrap_h, wrap_v;
  logic [31:0] inv_dx, inv_dy;

  stencil_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic longint clamp32(longint v, inout bit sat);
    if (v > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  function automatic longint pot_of(int a);
    return longint'($signed(pot_mem[a]));
  endfunction

  // coeff * d * inv on magnitudes, truncating toward zero
  function automatic longint face_term(bit [31:0] coeff, longint d, bit [31:0] inv,
                                       inout bit sat);
    bit [63:0] mag, m1, hi, lo, m2;
    longint t;
    mag = (d < 0) ? -d : d;
    if (mag > 64'hFFFF_FFFF) m1 = {32'b0, coeff} << 16;
    else m1 = ({32'b0, coeff} * mag) >> 16;
    hi = m1 * {48'b0, inv[31:16]};
    lo = (m1 * {48'b0, inv[15:0]}) >> 16;
    if (hi >= 64'h1_0000_0000 || lo >= 64'h1_0000_0000 || hi + lo >= 64'h1_0000_0000)
      m2 = 64'h1_0000_0000;
    else
      m2 = hi + lo;
    t = (d < 0) ? -longint'(m2) : longint'(m2);
    return clamp32(t, sat);
  endfunction

  function automatic stencil_result_t stencil_at(int col, int row);
    stencil_result_t r;
    int w, h, c, n;
    longint pc, acc, term;
    bit sat;
    w = (grid_w == 0) ? 1 : (grid_w > COLS) ? COLS : int'(grid_w);
    h = (grid_h == 0) ? 1 : (grid_h > ROWS) ? ROWS : int'(grid_h);
    acc = 0;
    sat = 1'b0;
    if (col >= w || row >= h) begin
      r.value = '0;
      r.status = ST_OUTSIDE;
      return r;
    end
    c = row * COLS + col;
    pc = pot_of(c);
    if (!act_mem[c]) begin
      r.value = pot_mem[c];
      r.status = ST_OK;
      return r;
    end
    // each term is computed on its own so its clamp flag is kept
    if (col + 1 < w || wrap_h) begin
      n = row * COLS + ((col + 1 < w) ? col + 1 : 0);
      if (act_mem[n]) begin
        term = face_term(east_mem[c], pc - pot_of(n), inv_dx, sat);
        acc = clamp32(acc + term, sat);
      end
    end
    if (col > 0 || wrap_h) begin
      n = row * COLS + ((col > 0) ? col - 1 : w - 1);
      if (act_mem[n]) begin
        term = face_term(east_mem[n], pc - pot_of(n), inv_dx, sat);
        acc = clamp32(acc + term, sat);
      end
    end
    if (row + 1 < h || wrap_v) begin
      n = ((row + 1 < h) ? row + 1 : 0) * COLS + col;
      if (act_mem[n]) begin
        term = face_term(north_mem[c], pc - pot_of(n), inv_dy, sat);
        acc = clamp32(acc + term, sat);
      end
    end
    if (row > 0 || wrap_v) begin
      n = ((row > 0) ? row - 1 : h - 1) * COLS + col;
      if (act_mem[n]) begin
        term = face_term(north_mem[n], pc - pot_of(n), inv_dy, sat);
        acc = clamp32(acc + term, sat);
      end
    end
    r.value = acc[31:0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    results_seen = 0;
    sat_seen = 0;
    outside_seen = 0;
  end

  always @(posedge clk) begin
    stencil_result_t exp_r;
    int a;
    if (!rst_n) begin
      grid_w <= 7'd64;
      grid_h <= 7'd64;
      wrap_h <= 1'b1;
      wrap_v <= 1'b1;
      inv_dx <= 32'd65536;
      inv_dy <= 32'd65536;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result value=%h status=%0d", $realtime,
                     out_operator_value, out_status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_operator_value !== exp_r.value || out_status !== exp_r.status) begin
            if (fail_count < 10)
              $display("[%0t] mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                       $realtime, exp_r.value, exp_r.status, out_operator_value, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_kind == KIND_LOAD) begin
          a = int'(in_cell_row) * COLS + int'(in_cell_col);
          pot_mem[a]   <= in_potential;
          east_mem[a]  <= in_east_coeff;
          north_mem[a] <= in_north_coeff;
          act_mem[a]   <= in_active_bit;
        end else begin
          exp_r = stencil_at(int'(in_cell_col), int'(in_cell_row));
          if (exp_r.status == ST_SAT) sat_seen <= sat_seen + 1;
          if (exp_r.status == ST_OUTSIDE) outside_seen <= outside_seen + 1;
          expected_results.push_back(exp_r);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_w <= cfg_data[6:0];
          REG_GRID_HEIGHT: grid_h <= cfg_data[6:0];
          REG_WRAP_H:      wrap_h <= cfg_data[0];
          REG_WRAP_V:      wrap_v <= cfg_data[0];
          REG_INV_DX_SQ:   inv_dx <= cfg_data;
          REG_INV_DY_SQ:   inv_dy <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/variable_coeff_laplacian_stencil_tb.sv
// testbench top for variable_coeff_laplacian_stencil: clock, reset, config phases,
// directed and random load/evaluate stimulus, watchdog and verdict
// depends on vcls_pkg, the block and variable_coeff_laplacian_stencil_checker
`timescale 1ns / 1ps

module variable_coeff_laplacian_stencil_tb import vcls_pkg::*;;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_kind = KIND_LOAD;
  logic [5:0]           in_cell_col = '0;
  logic [5:0]           in_cell_row = '0;
  logic signed [31:0]   in_potential = '0;
  logic [31:0]          in_east_coeff = '0;
  logic [31:0]          in_north_coeff = '0;
  logic                 in_active_bit = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
  logic [31:0]          cfg_data = '0;
  logic                 out_valid;
  logic signed [31:0]   out_operator_value;
  logic [1:0]           out_status;

  int fail_count, pending, results_seen, sat_seen, outside_seen;
  int idle_cycles = 0;
  int items_sent = 0;
  int cur_w = 64, cur_h = 64;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  variable_coeff_laplacian_stencil u_dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_cell_col, .in_cell_row, .in_potential,
    .in_east_coeff, .in_north_coeff, .in_active_bit, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .out_valid, .out_operator_value, .out_status
  );

  variable_coeff_laplacian_stencil_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_kind, .in_cell_col, .in_cell_row, .in_potential,
    .in_east_coeff, .in_north_coeff, .in_active_bit, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .out_valid, .out_operator_value, .out_status, .fail_count, .pending,
    .results_seen, .sat_seen, .outside_seen
  );

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called and returns at a falling edge
  task automatic send_item(logic kind, int col, int row, logic [31:0] pot,
                           logic [31:0] ec, logic [31:0] nc, logic act);
    int gap;
    in_kind = kind;
    in_cell_col = col[5:0];
    in_cell_row = row[5:0];
    in_potential = pot;
    in_east_coeff = ec;
    in_north_coeff = nc;
    in_active_bit = act;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(int w, int h, bit wh, bit wv, logic [31:0] dx, logic [31:0] dy);
    wait_drained();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_WRAP_H, 32'(wh));
    write_reg(REG_WRAP_V, 32'(wv));
    write_reg(REG_INV_DX_SQ, dx);
    write_reg(REG_INV_DY_SQ, dy);
    cur_w = (w == 0) ? 1 : (w > 64) ? 64 : w;
    cur_h = (h == 0) ? 1 : (h > 64) ? 64 : h;
  endtask

  function automatic logic [31:0] rand_pot();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(0, 32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_coord(int lim);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, (lim < 63) ? lim : 63);
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      // hold off once, halfway through, until the pipeline is empty
      if (i == count / 2) wait_drained();
      send_item(1'($urandom_range(0, 1)), rand_coord(cur_w), rand_coord(cur_h), rand_pot(),
                rand_coeff(), rand_coeff(), $urandom_range(0, 6) != 0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // every cell that any grid setting below can reach is written once:
    // the 16 x 8 corner, the whole first row and the first two columns
    no_gaps = 1'b1;
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++)
        if ((r < 8 && c < 16) || r == 0 || c < 2)
          send_item(KIND_LOAD, c, r, rand_pot(), rand_coeff(), rand_coeff(),
                    $urandom_range(0, 4) != 0);
    no_gaps = 1'b0;

    // directed: small closed grid
    configure(4, 3, 1'b0, 1'b0, 32'd65536, 32'd65536);
    send_item(KIND_LOAD, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_LOAD, 1, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_item(KIND_LOAD, 0, 1, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_EVAL, 0, 0, '0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 1, 0, '0, '0, '0, 1'b0);
    send_item(KIND_LOAD, 2, 0, 32'h1234_5678, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_item(KIND_EVAL, 2, 0, '0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 63, 63, '0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 4, 0, '0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 0, 3, '0, '0, '0, 1'b0);
    send_item(KIND_LOAD, 50, 50, 32'hFFFF_0000, 32'h0002_0000, 32'h0, 1'b1);
    send_item(KIND_LOAD, 1, 1, 32'h0, 32'h0001_8000, 32'h0000_8000, 1'b1);
    send_item(KIND_LOAD, 2, 1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 1'b1);
    send_item(KIND_LOAD, 1, 2, 32'h0000_0001, 32'h0001_0000, 32'h0001_0000, 1'b1);
    send_item(KIND_EVAL, 1, 1, '0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 3, 2, '0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 0, 1, '0, '0, '0, 1'b0);
    random_items(ITEMS_PER_PHASE);

    for (int p = 1; p < NUM_PHASES; p++) begin
      case (p)
        1: configure(16, 8, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: configure(1, 1, 1'b1, 1'b1, 32'd65536, 32'd0);
        3: configure(0, 127, 1'b0, 1'b1, 32'd0, 32'h0002_0000);
        4: configure(8, 8, 1'b1, 1'b0, 32'h0000_8000, 32'h0003_0000);
        5: configure(127, 0, 1'b1, 1'b1, 32'd65536, 32'd65536);
        6: configure(16, 5, 1'b0, 1'b0, $urandom, $urandom);
        default: configure(2, 64, 1'b1, 1'b0, $urandom_range(0, 32'h0004_0000),
                           $urandom_range(0, 32'h0004_0000));
      endcase
      if (p == 5) send_item(KIND_EVAL, 50, 0, '0, '0, '0, 1'b0);
      random_items(ITEMS_PER_PHASE);
    end

    wait_drained();
    $display("run covered %0d transactions over %0d register settings, %0d results",
             items_sent, NUM_PHASES, results_seen);
    $display("of those results %0d saturated and %0d were outside the grid",
             sat_seen, outside_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
